@@ hw/rtl/ohbf_pkg.sv @@
// Shared types and constants for the one-hashing Bloom filter.
package ohbf_pkg;

   localparam int HASH_BITS = 128;
   localparam int SIZE_BITS = 17;
   localparam int NUM_REGS  = 7;
   localparam int IDX_BITS  = 3;

   typedef enum logic [IDX_BITS-1:0] {
      REG_NUM_PARTS = 3'd0,
      REG_SIZE_0    = 3'd1,
      REG_SIZE_1    = 3'd2,
      REG_SIZE_2    = 3'd3,
      REG_SIZE_3    = 3'd4,
      REG_SIZE_4    = 3'd5,
      REG_SIZE_5    = 3'd6
   } reg_index_type;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_CHECK  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [63:0] hash_low;
      logic [63:0] hash_high;
   } req_type;

   typedef struct packed {
      logic present;
      logic size_error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_READ,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;      // capture a request
      logic clear;     // write zero to the clear address, advance it
      logic sum_step;  // add the next partition size to the running total
      logic div_start; // begin reduction of the hash for the current partition
      logic div_step;  // one restoring-division step
      logic mem_read;  // issue the bit-memory read
      logic update;    // apply/check the bit, advance partition
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clear_done;
      logic sum_last;
      logic sum_error;
      logic div_done;
      logic part_last;
   } status_type;

endpackage

@@ hw/rtl/ohbf_ctrl.sv @@
// Controller state machine for the one-hashing Bloom filter.
module ohbf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ohbf_pkg::status_type  status,
   output ohbf_pkg::cmd_type     cmd
);
   import ohbf_pkg::*;

   state_type state_ff, state_in;

   // Advance state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Select next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_SUM;
         ST_SUM: begin
            if (status.sum_error) state_in = ST_OUT;
            else if (status.sum_last) state_in = ST_DIV;
         end
         ST_DIV:    if (status.div_done) state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = status.part_last ? ST_OUT : ST_DIV;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Drive commands.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SUM: begin
            cmd.sum_step  = 1'b1;
            cmd.div_start = status.sum_last && !status.sum_error;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.mem_read = status.div_done;
         end
         ST_READ: begin
            // Wait for the read data.
         end
         ST_UPDATE: begin
            cmd.update    = 1'b1;
            cmd.div_start = !status.part_last;
         end
         ST_OUT: rsp_valid = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

@@ hw/rtl/ohbf_datapath.sv @@
// Datapath: size sum, serial modulo unit and bit-vector memory.
module ohbf_datapath #(
   parameter int MAX_PARTS   = 6,
   parameter int VECTOR_BITS = 65536
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ohbf_pkg::cmd_type                         cmd,
   output ohbf_pkg::status_type                      status,
   input  ohbf_pkg::req_type                         req_data,
   input  logic [2:0]                                num_parts,
   input  logic [MAX_PARTS-1:0][ohbf_pkg::SIZE_BITS-1:0] part_size,
   output ohbf_pkg::rsp_type                         rsp_data
);
   import ohbf_pkg::*;

   localparam int WORDS     = (VECTOR_BITS + 63) / 64;
   localparam int WADDR     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PBITS     = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CNTB      = $clog2(HASH_BITS + 1);
   localparam int TOTB      = 24;
   localparam int BITB      = TOTB;

   logic [63:0]      mem [WORDS];
   req_type          req_ff;
   logic [2:0]       count_ff;
   logic [PBITS-1:0] part_ff, part_in;
   logic [TOTB-1:0]  total_ff, offset_ff;
   logic [SIZE_BITS-1:0] div_ff;
   logic [SIZE_BITS:0]   rem_ff;
   logic [HASH_BITS-1:0] sh_ff;
   logic [CNTB-1:0]  cnt_ff;
   logic [WADDR-1:0] clr_ff;
   logic             clr_done_ff;
   logic [BITB-1:0]  bit_ff;
   logic             inrange_ff;
   logic [63:0]      rd_ff;
   logic             all_ff, err_ff;
   logic [SIZE_BITS-1:0] cur_size;
   logic [TOTB-1:0]  total_in;
   logic [SIZE_BITS:0]   trial;
   logic [SIZE_BITS+1:0] diff;
   logic [BITB-1:0]  bit_in;
   logic [2:0]       cnt_eff;

   function automatic logic [SIZE_BITS-1:0] fix(input logic [SIZE_BITS-1:0] s);
      fix = (s == '0) ? SIZE_BITS'(1) : s;
   endfunction
   function automatic logic [SIZE_BITS-1:0] part_size_first(
      input logic [MAX_PARTS-1:0][SIZE_BITS-1:0] ps);
      part_size_first = fix(ps[0]);
   endfunction
   function automatic logic [SIZE_BITS-1:0] part_size_next(
      input logic [MAX_PARTS-1:0][SIZE_BITS-1:0] ps, input logic [PBITS-1:0] p);
      logic [PBITS-1:0] n;
      n = p + PBITS'(1);
      part_size_next = fix(ps[n]);
   endfunction

   // Partition count with zero and saturation handling.
   always_comb begin
      cnt_eff = num_parts;
      if (num_parts == 3'd0) cnt_eff = 3'd1;
      if (32'(num_parts) > MAX_PARTS) cnt_eff = 3'(MAX_PARTS);
   end

   // Size of the current partition, zero read as one.
   always_comb begin
      cur_size = part_size[part_ff];
      if (cur_size == '0) cur_size = SIZE_BITS'(1);
   end

   assign total_in = total_ff + TOTB'(cur_size);
   assign status.sum_last  = (3'(part_ff) + 3'd1 == count_ff);
   assign status.sum_error = total_in > TOTB'(VECTOR_BITS);
   assign status.div_done  = (cnt_ff == CNTB'(HASH_BITS));
   assign status.part_last = (3'(part_ff) + 3'd1 == count_ff);
   assign status.clear_done = clr_done_ff;

   // One restoring step: shift in the next hash bit, subtract if it fits.
   assign trial = {rem_ff[SIZE_BITS-1:0], sh_ff[HASH_BITS-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_ff};
   assign bit_in = offset_ff + BITB'(rem_ff);

   always_comb begin
      part_in = part_ff;
      if (cmd.load) part_in = '0;
      else if (cmd.sum_step && status.sum_last) part_in = '0;
      else if (cmd.sum_step || cmd.update) part_in = part_ff + PBITS'(1);
   end

   // Control-side registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         part_ff     <= '0;
      end else begin
         part_ff <= part_in;
         if (cmd.clear) begin
            clr_ff <= clr_ff + WADDR'(1);
            if (32'(clr_ff) == WORDS - 1) clr_done_ff <= 1'b1;
         end
      end
   end

   // Capture request, sum sizes, run the divider, track the result.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff    <= req_data;
         count_ff  <= cnt_eff;
         total_ff  <= '0;
         offset_ff <= '0;
         all_ff    <= 1'b1;
         err_ff    <= 1'b0;
      end
      if (cmd.sum_step) begin
         total_ff <= total_in;
         if (status.sum_error) err_ff <= 1'b1;
      end
      if (cmd.div_start) begin
         sh_ff  <= {req_ff.hash_high, req_ff.hash_low};
         rem_ff <= '0;
         cnt_ff <= '0;
         div_ff <= cmd.update ? part_size_next(part_size, part_ff) : part_size_first(part_size);
      end else if (cmd.div_step && !status.div_done) begin
         sh_ff  <= {sh_ff[HASH_BITS-2:0], 1'b0};
         cnt_ff <= cnt_ff + CNTB'(1);
         if (!diff[SIZE_BITS+1]) rem_ff <= diff[SIZE_BITS:0];
         else rem_ff <= trial;
      end
      if (cmd.mem_read) begin
         bit_ff     <= bit_in;
         inrange_ff <= (32'(bit_in) >> 6) < WORDS;
      end
      if (cmd.update) begin
         offset_ff <= offset_ff + TOTB'(cur_size);
         if (req_ff.action == ACT_CHECK && inrange_ff && !rd_ff[bit_ff[5:0]])
            all_ff <= 1'b0;
      end
   end

   // Bit-vector memory: clear sweep, read, then set on insert.
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.update && req_ff.action == ACT_INSERT && inrange_ff) begin
         mem[bit_ff[WADDR+5:6]] <= rd_ff | (64'd1 << bit_ff[5:0]);
      end
      if (cmd.mem_read) rd_ff <= mem[bit_in[WADDR+5:6]];
   end

   assign rsp_data.present    = !err_ff && req_ff.action == ACT_CHECK && all_ff;
   assign rsp_data.size_error = err_ff;

endmodule

@@ hw/rtl/one_hash_bloom_filter.sv @@
// Top level of the one-hashing Bloom filter.
// Usage:
//   req_ channel carries a transaction of action (insert/check) and a 128-bit
//   key hash; rsp_ channel returns present and size_error for each one.
//   csr_ port writes num_partitions (index 0) and part sizes (1..6); the user must write only while idle, unchecked.
// Operation: one item per transaction, handled one at a time. Each active
//   partition takes the bit-serial modulo unit over all 128 hash bits plus a
//   memory read-modify-write. The modulo unit is the rate-setting loop.
// Reset: synchronous, active high. After reset a clearing pass writes zero to
//   every word of the bit vector; req_stall stays high until it ends.
// Stall: when rsp_stall is high the response holds and no new request is
//   taken until it has gone.
module one_hash_bloom_filter #(
   parameter int MAX_PARTS   = 6,
   parameter int VECTOR_BITS = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ohbf_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ohbf_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [16:0]         csr_data
);
   import ohbf_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [2:0] num_parts_ff;
   logic [MAX_PARTS-1:0][SIZE_BITS-1:0] size_ff;

   // Hold the configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_parts_ff <= 3'd3;
         for (int i = 0; i < MAX_PARTS; i++) begin
            size_ff[i] <= (i == 0) ? SIZE_BITS'(21841) : (i == 1) ? SIZE_BITS'(21851) :
                          (i == 2) ? SIZE_BITS'(21839) : SIZE_BITS'(1);
         end
      end else if (csr_write) begin
         if (csr_index == REG_NUM_PARTS) begin
            num_parts_ff <= csr_data[2:0];
         end else begin
            for (int i = 0; i < MAX_PARTS; i++) begin
               if (32'(csr_index) == i + 1) size_ff[i] <= csr_data;
            end
         end
      end
   end

   ohbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ohbf_datapath #(
      .MAX_PARTS   (MAX_PARTS),
      .VECTOR_BITS (VECTOR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .num_parts (num_parts_ff),
      .part_size (size_ff),
      .rsp_data  (rsp_data)
   );

endmodule

@@ dv/ohbf_checker.sv @@
// Checker for the one-hashing Bloom filter: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module ohbf_checker
   import ohbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data,
   output int          pending,
   output int          fail_count
);

   localparam int PARTS      = 6;
   localparam int VEC_BITS   = 65536;
   localparam int WORD_TOTAL = VEC_BITS / 64;

   logic [63:0] filter_words [WORD_TOTAL];
   logic [2:0]  part_count;
   logic [16:0] part_len [PARTS];
   rsp_type     expected_rsp [$];

   assign pending = expected_rsp.size();

   // Work out the response of one request and update the filter copy.
   function automatic rsp_type filter_lookup(req_type r);
      rsp_type     res;
      int          count;
      int          sizes [PARTS];
      int          total;
      int          offset;
      int          bit_no;
      logic [127:0] h;
      logic        all_set;
      res = '0;
      h = {r.hash_high, r.hash_low};
      count = (part_count == 0) ? 1 : (part_count > PARTS) ? PARTS : part_count;
      total = 0;
      for (int i = 0; i < count; i++) begin
         sizes[i] = (part_len[i] == 0) ? 1 : part_len[i];
         total += sizes[i];
      end
      if (total > VEC_BITS) begin
         res.size_error = 1'b1;
         return res;
      end
      offset = 0;
      all_set = 1'b1;
      for (int i = 0; i < count; i++) begin
         bit_no = offset + int'(h % 128'(sizes[i]));
         offset += sizes[i];
         if (r.action == ACT_INSERT)
            filter_words[bit_no >> 6][bit_no & 63] = 1'b1;
         else if (!filter_words[bit_no >> 6][bit_no & 63])
            all_set = 1'b0;
      end
      res.present = (r.action == ACT_CHECK) && all_set;
      return res;
   endfunction

   // Track register writes, queue predictions, compare responses.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (filter_words[i]) filter_words[i] = '0;
         part_count = 3'd3;
         part_len[0] = 17'd21841;
         part_len[1] = 17'd21851;
         part_len[2] = 17'd21839;
         for (int i = 3; i < PARTS; i++) part_len[i] = 17'd1;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_NUM_PARTS)
               part_count = csr_data[2:0];
            else if (csr_index >= REG_SIZE_0 && csr_index <= REG_SIZE_5)
               part_len[csr_index - REG_SIZE_0] = csr_data;
         end
         if (req_valid && !req_stall)
            expected_rsp.push_back(filter_lookup(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with none outstanding: present=%b size_error=%b",
                           $realtime, rsp_data.present, rsp_data.size_error);
            end else begin
               want = expected_rsp.pop_front();
               if (want.present !== rsp_data.present
                   || want.size_error !== rsp_data.size_error) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch present exp %b got %b, size_error exp %b got %b",
                              $realtime, want.present, rsp_data.present,
                              want.size_error, rsp_data.size_error);
               end
            end
         end
      end
   end

endmodule

@@ dv/tb.sv @@
// Testbench top for the one-hashing Bloom filter: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb;
   import ohbf_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [16:0] csr_data;
   int          pending;
   int          fail_count;

   logic        quiet;
   logic        hold_request;
   logic [127:0] seen_hashes [$];

   one_hash_bloom_filter u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data
   );

   ohbf_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data,
      .pending, .fail_count
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, one long hold-off on request.
   always @(posedge clock) begin
      static int stall_left = 0;
      static bit hold_done = 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_done) begin
            stall_left = 3000;
            hold_done = 1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 99) < 5) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one transaction and hold it until it is taken, then maybe gap.
   task automatic send_request(logic act, logic [127:0] h);
      int gap;
      req_valid <= 1'b1;
      req_data  <= '{action: act, hash_low: h[63:0], hash_high: h[127:64]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACT_INSERT) seen_hashes.push_back(h);
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 40)
         gap = ($urandom_range(0, 99) < 8) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [16:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Drain outstanding responses before touching the registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_config(int n, int s0, int s1, int s2, int s3, int s4, int s5);
      wait_idle();
      write_reg(REG_NUM_PARTS, 17'(n));
      write_reg(REG_SIZE_0, 17'(s0));
      write_reg(REG_SIZE_1, 17'(s1));
      write_reg(REG_SIZE_2, 17'(s2));
      write_reg(REG_SIZE_3, 17'(s3));
      write_reg(REG_SIZE_4, 17'(s4));
      write_reg(REG_SIZE_5, 17'(s5));
   endtask

   // Random hashes, often reusing inserted keys so checks hit.
   task automatic random_items(int count);
      logic [127:0] h;
      for (int i = 0; i < count; i++) begin
         if (seen_hashes.size() > 0 && $urandom_range(0, 99) < 50)
            h = seen_hashes[$urandom_range(0, seen_hashes.size() - 1)];
         else
            h = {$urandom, $urandom, $urandom, $urandom};
         send_request($urandom_range(0, 1) ? ACT_CHECK : ACT_INSERT, h);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_stall) @(posedge clock);

      // Reset settings: extremes of the hash, check before and after insert.
      send_request(ACT_CHECK, '0);
      send_request(ACT_INSERT, '0);
      send_request(ACT_CHECK, '0);
      send_request(ACT_CHECK, '1);
      send_request(ACT_INSERT, '1);
      send_request(ACT_CHECK, '1);
      send_request(ACT_CHECK, {64'h8000_0000_0000_0000, 64'h1});
      random_items(40);

      // One partition covering the whole vector; no idling here.
      set_config(1, 65536, 1, 1, 1, 1, 1);
      quiet = 1'b1;
      send_request(ACT_INSERT, {64'h0, 64'hFFFF});
      send_request(ACT_CHECK, {64'h0, 64'hFFFF});
      random_items(50);
      quiet = 1'b0;

      // Six tiny partitions, long receiver hold-off while requests keep coming.
      set_config(6, 2, 3, 5, 7, 11, 13);
      hold_request = 1'b1;
      random_items(70);

      // Zero count and zero size both act as one.
      set_config(0, 0, 0, 0, 0, 0, 0);
      send_request(ACT_CHECK, {$urandom, $urandom, $urandom, $urandom});
      random_items(30);

      // Count above the maximum saturates; unused register index is ignored.
      set_config(7, 10000, 10007, 10009, 10037, 10039, 0);
      write_reg(REG_UNUSED, 17'h1FFFF);
      random_items(60);

      // Oversized partitions: size error, vector left alone; then one partition just under the vector size.
      set_config(2, 65536, 1, 1, 1, 1, 1);
      send_request(ACT_INSERT, '1);
      send_request(ACT_CHECK, '1);
      set_config(6, 131071, 131071, 131071, 131071, 131071, 131071);
      random_items(20);
      set_config(1, 65535, 1, 1, 1, 1, 1);
      random_items(20);

      // Back to typical primes.
      set_config(3, 21841, 21851, 21839, 1, 1, 1);
      random_items(100);

      wait_idle();
      repeat (1000) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Overall limit.
   initial begin
      #8000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
